// File: hw/rtl/exalu_pkg.sv
`default_nettype none
package exalu_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int MODE_WIDTH     = 6;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_ADDU = 6'd1, OP_SUB = 6'd2, OP_SUBU = 6'd3,
        OP_MUL = 6'd4, OP_MULU = 6'd5, OP_DIV = 6'd6, OP_DIVU = 6'd7,
        OP_XOR = 6'd8, OP_NEG = 6'd9, OP_NOT = 6'd10, OP_REM = 6'd11,
        OP_REMU = 6'd12, OP_ADDR = 6'd13, OP_STORE = 6'd14,
        OP_SEQ = 6'd15, OP_SGE = 6'd16, OP_SGT = 6'd17, OP_SLE = 6'd18,
        OP_SLT = 6'd19, OP_SNE = 6'd20,
        OP_BEQ = 6'd21, OP_BNE = 6'd22, OP_BGE = 6'd23, OP_BLE = 6'd24,
        OP_BGT = 6'd25, OP_BLT = 6'd26,
        OP_BEQZ = 6'd27, OP_BNEZ = 6'd28, OP_BGEZ = 6'd29, OP_BLEZ = 6'd30,
        OP_BGTZ = 6'd31, OP_BLTZ = 6'd32,
        OP_LINK = 6'd33, OP_MOVE = 6'd34, OP_MFHI = 6'd35, OP_MFLO = 6'd36,
        OP_NOP = 6'd37
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_ITER, ST_FIX, ST_OUT
    } state_t;
endpackage
`default_nettype wire

// File: hw/rtl/execute_stage_alu_hi_lo_top.sv
// Execute stage with hi/lo pair. Operations other than multiply and divide are
// offered on the output in the cycle after the input transfer (the output
// register). Multiply and divide/remainder share one add/subtract-and-shift unit
// that handles one operand bit per cycle: the item passes through the iteration
// state, a fix-up state for signs and hi/lo, and the output state. A new item is
// taken only once the result has been transferred. Division by zero gives all
// ones and the dividend as remainder.
`default_nettype none
module execute_stage_alu_hi_lo_top
    import exalu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode[5:0], operand_a[37:6], operand_b[69:38], immediate[101:70],
    // next_index[133:102], has_destination[134], zero pad
    input  wire logic [135:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // alu_value[31:0], target_address[63:32]
    output logic [63:0]      m_tdata
);
    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);

    state_t state_reg, state_next;
    op_t    op_reg;
    logic   dest_reg;
    logic [W-1:0] hi_reg, lo_reg;
    logic [W-1:0] acc_reg, sh_reg, b_reg;
    logic [CW-1:0] cnt_reg;
    logic neg_q_reg, neg_r_reg;
    logic [W-1:0] alu_reg, addr_reg;

    logic [5:0]  in_mode;
    logic [W-1:0] in_a, in_b;
    logic [FIELD_WIDTH-1:0] in_imm, in_nxt;
    logic in_dest;
    assign in_mode = s_tdata[5:0];
    assign in_a    = W'(s_tdata[37:6]);
    assign in_b    = W'(s_tdata[69:38]);
    assign in_imm  = s_tdata[101:70];
    assign in_nxt  = s_tdata[133:102];
    assign in_dest = s_tdata[134];

    function automatic logic lts(input logic [W-1:0] x, input logic [W-1:0] y);
        lts = $signed(x) < $signed(y);
    endfunction

    logic is_mul, is_div, sgn_op, acc_in;
    assign is_mul = (in_mode == OP_MUL) || (in_mode == OP_MULU);
    assign is_div = (in_mode == OP_DIV) || (in_mode == OP_DIVU) ||
                    (in_mode == OP_REM) || (in_mode == OP_REMU);
    assign sgn_op = (in_mode == OP_MUL) || (in_mode == OP_DIV) || (in_mode == OP_REM);
    assign acc_in = s_tvalid && s_tready;

    logic [W-1:0] abs_a, abs_b;
    assign abs_a = (sgn_op && in_a[W-1]) ? W'(-in_a) : in_a;
    assign abs_b = (sgn_op && in_b[W-1]) ? W'(-in_b) : in_b;

    // combinational datapath for non-iterative operations
    logic [W-1:0] s_alu, s_addr, cmp_c;
    logic cond;
    always_comb begin
        s_alu  = '0;
        s_addr = '0;
        cond   = 1'b0;
        cmp_c  = (in_mode >= OP_BEQZ) ? '0 : in_b;
        case (in_mode)
            OP_ADD, OP_ADDU: s_alu = in_a + in_b;
            OP_SUB, OP_SUBU: s_alu = in_a - in_b;
            OP_XOR:   s_alu = in_a ^ in_b;
            OP_NEG:   s_alu = W'(-in_a);
            OP_NOT:   s_alu = ~in_a;
            OP_ADDR:  s_addr = W'(in_imm) + in_a;
            OP_STORE: begin
                s_addr = W'(in_imm) + in_a;
                s_alu  = in_b;
            end
            OP_SEQ:  s_alu = W'(in_a == in_b);
            OP_SGE:  s_alu = W'(!lts(in_a, in_b));
            OP_SGT:  s_alu = W'(lts(in_b, in_a));
            OP_SLE:  s_alu = W'(!lts(in_b, in_a));
            OP_SLT:  s_alu = W'(lts(in_a, in_b));
            OP_SNE:  s_alu = W'(in_a != in_b);
            OP_LINK: s_addr = W'(in_nxt);
            OP_MOVE: s_alu = in_a;
            OP_MFHI: s_alu = hi_reg;
            OP_MFLO: s_alu = lo_reg;
            OP_BEQ, OP_BEQZ: cond = in_a == cmp_c;
            OP_BNE, OP_BNEZ: cond = in_a != cmp_c;
            OP_BGE, OP_BGEZ: cond = !lts(in_a, cmp_c);
            OP_BLE, OP_BLEZ: cond = !lts(cmp_c, in_a);
            OP_BGT, OP_BGTZ: cond = lts(cmp_c, in_a);
            OP_BLT, OP_BLTZ: cond = lts(in_a, cmp_c);
            default: ;
        endcase
        if (in_mode >= OP_BEQ && in_mode <= OP_BLTZ)
            s_addr = cond ? W'(in_imm) : W'(in_nxt);
    end

    // shared add/subtract unit
    logic op_is_mul;
    assign op_is_mul = (op_reg == OP_MUL) || (op_reg == OP_MULU);
    logic [W:0] rem_sh, unit_sum;
    assign rem_sh = {acc_reg, sh_reg[W-1]};
    always_comb begin
        if (op_is_mul)
            unit_sum = {1'b0, acc_reg} + (sh_reg[0] ? {1'b0, b_reg} : '0);
        else
            unit_sum = rem_sh - {1'b0, b_reg};
    end

    logic [W-1:0] q_fix, r_fix, p_hi, p_lo;
    logic [2*W-1:0] prod;
    assign prod = {acc_reg, sh_reg};
    assign p_hi = neg_q_reg ? W'((~prod + 1'b1) >> W) : acc_reg;
    assign p_lo = neg_q_reg ? W'(~prod + 1'b1) : sh_reg;
    assign q_fix = neg_q_reg ? W'(-sh_reg) : sh_reg;
    assign r_fix = neg_r_reg ? W'(-acc_reg) : acc_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (acc_in) state_next = (is_mul || is_div) ? ST_ITER : ST_OUT;
            ST_ITER: if (cnt_reg == CW'(W - 1)) state_next = ST_FIX;
            ST_FIX:  state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = {FIELD_WIDTH'(addr_reg), FIELD_WIDTH'(alu_reg)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIX && !dest_reg) begin
                if (op_is_mul) begin
                    hi_reg <= p_hi;
                    lo_reg <= p_lo;
                end else if (op_reg == OP_DIV || op_reg == OP_DIVU) begin
                    hi_reg <= r_fix;
                    lo_reg <= q_fix;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: if (acc_in) begin
                op_reg   <= op_t'(in_mode);
                dest_reg <= in_dest;
                alu_reg  <= s_alu;
                addr_reg <= s_addr;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                sh_reg   <= abs_a;
                b_reg    <= abs_b;
                if (is_mul) begin
                    neg_q_reg <= sgn_op && (in_a[W-1] ^ in_b[W-1]);
                    neg_r_reg <= 1'b0;
                end else begin
                    neg_q_reg <= sgn_op && (in_a[W-1] ^ in_b[W-1]) && (in_b != '0);
                    neg_r_reg <= sgn_op && in_a[W-1];
                end
            end
            ST_ITER: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (op_is_mul) begin
                    {acc_reg, sh_reg} <= {unit_sum, sh_reg[W-1:1]};
                end else if (!unit_sum[W]) begin
                    acc_reg <= unit_sum[W-1:0];
                    sh_reg  <= {sh_reg[W-2:0], 1'b1};
                end else begin
                    acc_reg <= rem_sh[W-1:0];
                    sh_reg  <= {sh_reg[W-2:0], 1'b0};
                end
            end
            ST_FIX: begin
                if (op_is_mul) begin
                    if (dest_reg) alu_reg <= p_lo;
                end else if (op_reg == OP_REM || op_reg == OP_REMU) begin
                    alu_reg <= r_fix;
                end else if (dest_reg) begin
                    alu_reg <= q_fix;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: verif/tb_execute_stage_alu_hi_lo_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_execute_stage_alu_hi_lo_top;
    import exalu_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;

    execute_stage_alu_hi_lo_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] alu_value;
        logic [31:0] target_address;
    } exec_result_t;

    logic [31:0]  hi_reg = '0;
    logic [31:0]  lo_reg = '0;
    exec_result_t pending_results[$];
    int           error_count = 0;
    int           hold_off_cycles = 0;
    bit           no_idle = 1'b0;

    function automatic logic [31:0] div_quot(logic [31:0] a, logic [31:0] b, bit sgn);
        logic [31:0] ma, mb, q;
        if (b == 0) return '1;
        if (!sgn) return a / b;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] div_rem(logic [31:0] a, logic [31:0] b, bit sgn);
        logic [31:0] ma, mb, r;
        if (b == 0) return a;
        if (!sgn) return a % b;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        r = ma % mb;
        return a[31] ? -r : r;
    endfunction

    // updates hi/lo as the block does
    function automatic exec_result_t execute_op(logic [5:0] mode, logic [31:0] a,
            logic [31:0] b, logic [31:0] imm, logic [31:0] nxt, logic dest);
        exec_result_t res;
        logic [63:0]  prod;
        logic [31:0]  c;
        logic         cond;
        res = '0;
        cond = 1'b0;
        c = (mode >= OP_BEQZ) ? 32'd0 : b;
        case (mode)
            OP_ADD, OP_ADDU: res.alu_value = a + b;
            OP_SUB, OP_SUBU: res.alu_value = a - b;
            OP_MUL, OP_MULU: begin
                if (mode == OP_MUL) prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                else prod = {32'd0, a} * {32'd0, b};
                if (dest) res.alu_value = prod[31:0];
                else begin
                    hi_reg = prod[63:32];
                    lo_reg = prod[31:0];
                end
            end
            OP_DIV, OP_DIVU: begin
                if (dest) res.alu_value = div_quot(a, b, mode == OP_DIV);
                else begin
                    lo_reg = div_quot(a, b, mode == OP_DIV);
                    hi_reg = div_rem(a, b, mode == OP_DIV);
                end
            end
            OP_XOR: res.alu_value = a ^ b;
            OP_NEG: res.alu_value = -a;
            OP_NOT: res.alu_value = ~a;
            OP_REM, OP_REMU: res.alu_value = div_rem(a, b, mode == OP_REM);
            OP_ADDR: res.target_address = imm + a;
            OP_STORE: begin
                res.target_address = imm + a;
                res.alu_value = b;
            end
            OP_SEQ: res.alu_value = {31'd0, a == b};
            OP_SGE: res.alu_value = {31'd0, $signed(a) >= $signed(b)};
            OP_SGT: res.alu_value = {31'd0, $signed(a) > $signed(b)};
            OP_SLE: res.alu_value = {31'd0, $signed(a) <= $signed(b)};
            OP_SLT: res.alu_value = {31'd0, $signed(a) < $signed(b)};
            OP_SNE: res.alu_value = {31'd0, a != b};
            OP_BEQ, OP_BEQZ, OP_BNE, OP_BNEZ, OP_BGE, OP_BGEZ,
            OP_BLE, OP_BLEZ, OP_BGT, OP_BGTZ, OP_BLT, OP_BLTZ: begin
                case ((mode - OP_BEQ) % 6)
                    0: cond = a == c;
                    1: cond = a != c;
                    2: cond = $signed(a) >= $signed(c);
                    3: cond = $signed(a) <= $signed(c);
                    4: cond = $signed(a) > $signed(c);
                    default: cond = $signed(a) < $signed(c);
                endcase
                res.target_address = cond ? imm : nxt;
            end
            OP_LINK: res.target_address = nxt;
            OP_MOVE: res.alu_value = a;
            OP_MFHI: res.alu_value = hi_reg;
            OP_MFLO: res.alu_value = lo_reg;
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_op(logic [5:0] mode, logic [31:0] a, logic [31:0] b,
            logic [31:0] imm, logic [31:0] nxt, logic dest);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= {1'b0, dest, nxt, imm, b, a, mode};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(execute_op(mode, a, b, imm, nxt, dest));
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '1;
            3: return $urandom_range(7);
            4: return -$urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_op(OP_MFHI, 0, 0, 0, 0, 1);
        send_op(OP_MFLO, 0, 0, 0, 0, 1);
        send_op(OP_ADD, '1, 32'd1, '1, '1, 1);
        send_op(OP_SUB, 0, 32'd1, 0, 0, 1);
        send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_op(OP_MFHI, 0, 0, 0, 0, 1);
        send_op(OP_MFLO, 0, 0, 0, 0, 1);
        send_op(OP_MULU, '1, '1, 0, 0, 0);
        send_op(OP_MFHI, 0, 0, 0, 0, 1);
        send_op(OP_DIV, 32'h8000_0000, '1, 0, 0, 0);
        send_op(OP_MFHI, 0, 0, 0, 0, 1);
        send_op(OP_MFLO, 0, 0, 0, 0, 1);
        send_op(OP_DIVU, 32'd1234, 0, 0, 0, 0);
        send_op(OP_MFHI, 0, 0, 0, 0, 1);
        send_op(OP_MFLO, 0, 0, 0, 0, 1);
        send_op(OP_DIV, 32'hffff_fff9, 32'd2, 0, 0, 1);
        send_op(OP_REM, 32'hffff_fff9, 32'd2, 0, 0, 1);
        send_op(OP_REM, 32'hffff_fff9, 0, 0, 0, 1);
        send_op(OP_REMU, 32'd5, 0, 0, 0, 1);
        send_op(OP_NEG, 32'h8000_0000, 0, 0, 0, 1);
        send_op(OP_NOT, 32'h0f0f_0000, 0, 0, 0, 1);
        send_op(OP_STORE, 32'd4, '1, '1, 0, 1);
        send_op(OP_BLT, 32'h8000_0000, 32'd1, 32'haaaa_5555, 32'h5555_aaaa, 1);
        send_op(OP_LINK, 0, 0, 0, '1, 1);
        send_op(6'd63, '1, '1, '1, '1, 1);
    endtask

    task automatic test_random(int count);
        logic [5:0] mode;
        for (int i = 0; i < count; i++) begin
            no_idle = (i >= count / 2) && (i < count / 2 + 100);
            mode = ($urandom_range(15) == 0) ? 6'($urandom_range(63, 38))
                                              : 6'($urandom_range(OP_NOP));
            send_op(mode, rand_operand(), rand_operand(), $urandom, $urandom,
                    1'($urandom));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 200;
        for (int i = 0; i < 8; i++)
            send_op(6'($urandom_range(OP_NOP)), $urandom, $urandom, $urandom, $urandom,
                    1'($urandom));
    endtask

    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge aclk) begin
        exec_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transfer %h", m_tdata);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata[31:0] !== exp_res.alu_value) begin
                    $error("alu_value expected %h actual %h", exp_res.alu_value, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[63:32] !== exp_res.target_address) begin
                    $error("target_address expected %h actual %h",
                           exp_res.target_address, m_tdata[63:32]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int wait_cycles;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(1300);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (50) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hw/rtl/exalu_pkg.sv
hw/rtl/execute_stage_alu_hi_lo_top.sv
verif/tb_execute_stage_alu_hi_lo_top.sv
